### hw/rtl/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg: shared types and constants of the priority scheduler
// Holds the slot count, the field widths, the word structs of both channels
// and the control structs that pass between the scheduler's modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pps_pkg;

    localparam int SLOTS   = 16;
    localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int PEND_W  = 5;
    localparam int ID_W    = 16;
    localparam int PRIO_W  = 16;
    localparam int BURST_W = 16;
    localparam int ORDER_W = 32;

    localparam logic FUNC_ARRIVE = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    typedef logic [IDX_W-1:0]   slot_idx_t;
    typedef logic [CNT_W-1:0]   slot_cnt_t;
    typedef logic [ID_W-1:0]    task_id_t;
    typedef logic [PRIO_W-1:0]  task_prio_t;
    typedef logic [BURST_W-1:0] task_burst_t;
    typedef logic [ORDER_W-1:0] order_t;

    typedef struct packed {
        logic        func;
        task_id_t    task_id;
        task_prio_t  task_priority;
        task_burst_t task_burst;
    } in_word_t;

    typedef struct packed {
        task_id_t          ran_task;
        logic              dropped;
        logic [PEND_W-1:0] pending;
    } out_word_t;

    typedef struct packed {
        task_id_t    id;
        task_prio_t  prio;
        task_burst_t remaining;
        order_t      order;
    } slot_entry_t;

    typedef struct packed {
        logic        we;
        logic        set_valid;
        logic        clr_valid;
        slot_idx_t   addr;
        slot_entry_t entry;
    } table_wr_t;

    typedef struct packed {
        logic      full;
        slot_idx_t free_idx;
        slot_cnt_t count;
    } table_stat_t;

    typedef struct packed {
        logic        found;
        slot_idx_t   idx;
        task_id_t    id;
        task_prio_t  prio;
        task_burst_t remaining;
    } best_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ARRIVE,
        ST_SCAN,
        ST_APPLY,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

### hw/rtl/preemptive_priority_scheduler.sv
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler: preemptive priority scheduler, one processor
// Top level: handshake, sequencer, running-task registers and result word.
// ----------------------------------------------------------------------------
// The block takes one word at a time. An arrival word stores its task in the
// lowest free waiting slot, or flags it as dropped when all SLOTS slots are
// taken. A tick word reports the running task, decrements its remaining burst
// and then reads the slot memory one entry per cycle to find the best waiting
// task, as that memory has a single read port. Each result is loaded into the
// output register before the block returns to idle and can take the next word.
// A new word may be accepted while the previous result still waits on the
// output register.
// Every word yields exactly one result word, carrying the running id (ticks
// only), the drop flag (arrivals only) and the number of waiting tasks.
// There is no clearing pass: slot valid bits are reset in flip-flops.
// ----------------------------------------------------------------------------
`default_nettype none

module preemptive_priority_scheduler (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire pps_pkg::in_word_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output pps_pkg::out_word_t     m_data
);
    import pps_pkg::*;

    localparam int SCAN_W = IDX_W + 1;

    state_t        state_reg, state_next;
    in_word_t      in_reg;
    task_id_t      ran_reg;
    logic          drop_reg;
    logic [SCAN_W-1:0] scan_cnt_reg;

    logic          run_valid_reg;
    task_id_t      run_id_reg;
    task_prio_t    run_prio_reg;
    task_burst_t   run_rem_reg;
    task_burst_t   run_rem_dec;
    order_t        entry_cnt_reg;

    logic          m_valid_reg;
    out_word_t     m_data_reg;

    logic          accept;
    logic          scan_done;
    logic          rd_en;
    logic          take_task;
    logic          preempt;
    logic          load_out;
    table_wr_t     tbl_wr;
    table_stat_t   stat;
    slot_entry_t   rd_entry;
    logic          rd_ack;
    logic          rd_valid;
    slot_idx_t     rd_idx;
    best_t         best;
    logic          scan_busy;
    task_burst_t   burst_fixed;

    // ------------------------------------------------------------------
    // Slot memory and the scan that walks it.
    // ------------------------------------------------------------------
    pps_slot_table u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (tbl_wr),
        .rd_en    (rd_en),
        .rd_addr  (scan_cnt_reg[IDX_W-1:0]),
        .rd_entry (rd_entry),
        .rd_ack   (rd_ack),
        .rd_valid (rd_valid),
        .rd_idx   (rd_idx),
        .stat     (stat)
    );

    pps_best_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (accept),
        .in_go     (rd_ack),
        .in_valid  (rd_valid),
        .in_idx    (rd_idx),
        .in_entry  (rd_entry),
        .entry_cnt (entry_cnt_reg),
        .best      (best),
        .busy      (scan_busy)
    );

    assign accept      = s_valid && s_ready;
    assign run_rem_dec = run_rem_reg - task_burst_t'(1);
    assign burst_fixed = (in_reg.task_burst == '0) ? task_burst_t'(1) : in_reg.task_burst;

    // The scan is over once every slot has been issued and both the memory
    // read and the age stage have drained into the best-so-far registers.
    assign scan_done = (scan_cnt_reg == SCAN_W'(SLOTS)) && !rd_ack && !scan_busy;

    // ------------------------------------------------------------------
    // Sequencer: next state.
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (s_data.func == FUNC_TICK) ? ST_SCAN : ST_ARRIVE;
                end
            end
            ST_ARRIVE: state_next = ST_DONE;
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: state_next = ST_DONE;
            ST_DONE: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs. Arrivals write a free slot if there is one; after
    // a scan the best task is taken by an idle processor (its slot is freed),
    // swaps places with a lower-priority running task, which re-enters the
    // same slot with the newest entry order, or else stays where it is.
    // ------------------------------------------------------------------
    always_comb begin
        s_ready   = (state_reg == ST_IDLE);
        rd_en     = (state_reg == ST_SCAN) && (scan_cnt_reg < SCAN_W'(SLOTS));
        take_task = (state_reg == ST_APPLY) && best.found && !run_valid_reg;
        preempt   = (state_reg == ST_APPLY) && best.found && run_valid_reg &&
                    (best.prio > run_prio_reg);
        load_out  = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

        tbl_wr = '0;
        if ((state_reg == ST_ARRIVE) && !stat.full) begin
            tbl_wr.we              = 1'b1;
            tbl_wr.set_valid       = 1'b1;
            tbl_wr.addr            = stat.free_idx;
            tbl_wr.entry.id        = in_reg.task_id;
            tbl_wr.entry.prio      = in_reg.task_priority;
            tbl_wr.entry.remaining = burst_fixed;
            tbl_wr.entry.order     = entry_cnt_reg;
        end else if (take_task) begin
            tbl_wr.clr_valid = 1'b1;
            tbl_wr.addr      = best.idx;
        end else if (preempt) begin
            tbl_wr.we              = 1'b1;
            tbl_wr.addr            = best.idx;
            tbl_wr.entry.id        = run_id_reg;
            tbl_wr.entry.prio      = run_prio_reg;
            tbl_wr.entry.remaining = run_rem_reg;
            tbl_wr.entry.order     = entry_cnt_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            scan_cnt_reg  <= '0;
            entry_cnt_reg <= '0;
            run_valid_reg <= 1'b0;
            run_id_reg    <= '0;
            run_prio_reg  <= '0;
            run_rem_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (accept) begin
                scan_cnt_reg <= '0;
            end else if (rd_en) begin
                scan_cnt_reg <= scan_cnt_reg + SCAN_W'(1);
            end

            // Every slot write stamps the entry with the counter.
            if (tbl_wr.we) begin
                entry_cnt_reg <= entry_cnt_reg + order_t'(1);
            end

            // The running task is charged for the tick before the scan.
            if (accept && (s_data.func == FUNC_TICK) && run_valid_reg) begin
                run_rem_reg <= run_rem_dec;
                if (run_rem_dec == '0) begin
                    run_valid_reg <= 1'b0;
                end
            end else if (take_task || preempt) begin
                run_valid_reg <= 1'b1;
                run_id_reg    <= best.id;
                run_prio_reg  <= best.prio;
                run_rem_reg   <= best.remaining;
            end

            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Word capture and result assembly.
    always_ff @(posedge aclk) begin
        if (accept) begin
            in_reg   <= s_data;
            drop_reg <= 1'b0;
            ran_reg  <= ((s_data.func == FUNC_TICK) && run_valid_reg) ? run_id_reg : '0;
        end else if (state_reg == ST_ARRIVE) begin
            drop_reg <= stat.full;
        end
        if (load_out) begin
            m_data_reg.ran_task <= ran_reg;
            m_data_reg.dropped  <= drop_reg;
            m_data_reg.pending  <= PEND_W'(stat.count);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // A running task always has work left.
    a_run_rem_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        run_valid_reg |-> (run_rem_reg != '0))
        else $error("running task has no remaining burst");

    // The fill count never exceeds the number of slots.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.count <= CNT_W'(SLOTS))
        else $error("waiting count above slot count");

    // An arrival into a table with room adds exactly one waiting task.
    a_arrive_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_ARRIVE) && !stat.full) |=>
            (stat.count == $past(stat.count) + CNT_W'(1)))
        else $error("arrival did not add one waiting task");

    // Preemption swaps tasks in place, so the waiting count holds.
    a_preempt_count: assert property (@(posedge aclk) disable iff (!aresetn)
        preempt |=> (stat.count == $past(stat.count)))
        else $error("preemption changed the waiting count");

endmodule

`default_nettype wire

### hw/rtl/pps_slot_table.sv
// ----------------------------------------------------------------------------
// pps_slot_table: waiting-slot memory with valid bits
// One synchronous memory holds the slot entries; valid bits and the fill
// count live in flip-flops, and the lowest free slot is encoded from them.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_slot_table (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire pps_pkg::table_wr_t   wr,
    input  wire logic                 rd_en,
    input  wire pps_pkg::slot_idx_t   rd_addr,
    output pps_pkg::slot_entry_t      rd_entry,
    output logic                      rd_ack,
    output logic                      rd_valid,
    output pps_pkg::slot_idx_t        rd_idx,
    output pps_pkg::table_stat_t      stat
);
    import pps_pkg::*;

    slot_entry_t            mem [SLOTS];
    slot_entry_t            rd_entry_reg;
    logic                   rd_ack_reg;
    logic                   rd_valid_reg;
    slot_idx_t              rd_idx_reg;
    logic [SLOTS-1:0]       valid_reg, valid_next;
    slot_cnt_t              count_reg, count_next;
    slot_idx_t              free_idx;
    logic                   any_free;

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.addr] <= wr.entry;
        end
        if (rd_en) begin
            rd_entry_reg <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
            rd_idx_reg   <= rd_addr;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        count_next = count_reg;
        if (wr.set_valid) begin
            valid_next[wr.addr] = 1'b1;
            count_next          = count_reg + slot_cnt_t'(1);
        end else if (wr.clr_valid) begin
            valid_next[wr.addr] = 1'b0;
            count_next          = count_reg - slot_cnt_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            count_reg  <= '0;
            rd_ack_reg <= 1'b0;
        end else begin
            valid_reg  <= valid_next;
            count_reg  <= count_next;
            rd_ack_reg <= rd_en;
        end
    end

    // Lowest-numbered free slot wins.
    always_comb begin
        free_idx = '0;
        any_free = 1'b0;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (!valid_reg[k]) begin
                free_idx = slot_idx_t'(k);
                any_free = 1'b1;
            end
        end
    end

    assign stat.full     = !any_free;
    assign stat.free_idx = free_idx;
    assign stat.count    = count_reg;

    assign rd_entry = rd_entry_reg;
    assign rd_ack   = rd_ack_reg;
    assign rd_valid = rd_valid_reg;
    assign rd_idx   = rd_idx_reg;

endmodule

`default_nettype wire

### hw/rtl/pps_best_scan.sv
// ----------------------------------------------------------------------------
// pps_best_scan: running maximum over the slots read from the table
// A stage forms each entry's age, then a compare keeps the highest priority,
// and among equal priorities the youngest entry.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_best_scan (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic                 in_go,
    input  wire logic                 in_valid,
    input  wire pps_pkg::slot_idx_t   in_idx,
    input  wire pps_pkg::slot_entry_t in_entry,
    input  wire pps_pkg::order_t      entry_cnt,
    output pps_pkg::best_t            best,
    output logic                      busy
);
    import pps_pkg::*;

    logic        st_go_reg;
    logic        st_valid_reg;
    slot_idx_t   st_idx_reg;
    order_t      st_age_reg;
    task_id_t    st_id_reg;
    task_prio_t  st_prio_reg;
    task_burst_t st_rem_reg;

    logic        best_found_reg;
    slot_idx_t   best_idx_reg;
    order_t      best_age_reg;
    task_id_t    best_id_reg;
    task_prio_t  best_prio_reg;
    task_burst_t best_rem_reg;
    logic        take;

    always_ff @(posedge aclk) begin
        st_valid_reg <= in_valid;
        st_idx_reg   <= in_idx;
        st_age_reg   <= entry_cnt - in_entry.order;
        st_id_reg    <= in_entry.id;
        st_prio_reg  <= in_entry.prio;
        st_rem_reg   <= in_entry.remaining;
    end

    assign take = st_go_reg && st_valid_reg &&
                  (!best_found_reg || (st_prio_reg > best_prio_reg) ||
                   ((st_prio_reg == best_prio_reg) && (st_age_reg < best_age_reg)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_go_reg      <= 1'b0;
            best_found_reg <= 1'b0;
        end else if (start) begin
            st_go_reg      <= 1'b0;
            best_found_reg <= 1'b0;
        end else begin
            st_go_reg <= in_go;
            if (take) begin
                best_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            best_idx_reg  <= st_idx_reg;
            best_age_reg  <= st_age_reg;
            best_id_reg   <= st_id_reg;
            best_prio_reg <= st_prio_reg;
            best_rem_reg  <= st_rem_reg;
        end
    end

    assign best.found     = best_found_reg;
    assign best.idx       = best_idx_reg;
    assign best.id        = best_id_reg;
    assign best.prio      = best_prio_reg;
    assign best.remaining = best_rem_reg;
    assign busy           = st_go_reg;

endmodule

`default_nettype wire
